/* src/xcbr_pkg.sv */
`timescale 1ns / 1ps

package xcbr_pkg;

    // protocol bytes
    localparam logic [7:0] SOH_CODE = 8'h01;
    localparam logic [7:0] EOF_CODE = 8'h04;
    localparam logic [7:0] ACK_CODE = 8'h06;
    localparam logic [7:0] NAK_CODE = 8'h15;

    // input item kinds (tuser)
    localparam logic KIND_BYTE    = 1'b0;
    localparam logic KIND_TIMEOUT = 1'b1;

    // result kinds
    localparam logic RES_REPLY = 1'b0;
    localparam logic RES_WRITE = 1'b1;

    typedef enum logic [0:0] {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

    typedef struct packed {
        t_alu_op     op;
        logic [15:0] a;
        logic [15:0] b;
    } t_alu_req;

    typedef struct packed {
        logic [15:0] result;
        logic        zero8;   // low byte of result is zero
    } t_alu_rsp;

endpackage

/* src/xcbr_alu.sv */
`timescale 1ns / 1ps

module xcbr_alu
    import xcbr_pkg::*;
(
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    logic [15:0] w_b_op;
    logic [15:0] w_sum;

    // one adder; subtract as a + ~b + 1
    assign w_b_op = (i_req.op == ALU_SUB) ? ~i_req.b : i_req.b;
    assign w_sum  = i_req.a + w_b_op + {15'd0, (i_req.op == ALU_SUB)};

    assign o_rsp.result = w_sum;
    assign o_rsp.zero8  = (w_sum[7:0] == 8'd0);

endmodule

/* src/xmodem_checksum_block_receiver.sv */
`timescale 1ns / 1ps

// XMODEM-style checksum block receiver. Bytes of an upload come in on the
// slave stream one transaction at a time (tuser 0 = received byte, tuser 1 =
// receive timeout). A frame is SOH, block number, its complement, BLOCK_SIZE
// data bytes and an 8-bit sum. A good frame produces BLOCK_SIZE memory-write
// results at increasing addresses (from the write pointer, loaded by a base
// address write) followed by an ACK reply; a bad frame produces NAK (NAK then
// ACK with finished set if EOF-led). A timeout with nothing received replies
// ACK, after a partial frame starting with EOF it replies ACK with finished
// set and the transfer ends; otherwise NAK. Once finished, all input is
// accepted and dropped. A received byte is accepted, then an update step adds
// data bytes to the running sum; the closing byte of a frame adds a check
// step, then the data writes and the reply, which can stall on the output.
// The running sum, the write pointer and block number increments and the
// checksum compare use one shared 16-bit adder; the block buffer is a memory
// with one write and one registered read port. base_address may only be
// written while the block is idle; it also reloads the write pointer.

module xmodem_checksum_block_receiver
    import xcbr_pkg::*;
#(
    parameter int BLOCK_SIZE = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,     // base_address

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,      // [7:0] rx_byte
    input  logic        s_axis_tuser,      // [0] kind

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,      // [7:0] payload, [23:8] write_address
    output logic [1:0]  m_axis_tuser,      // [0] result_kind, [1] finished
    output logic        m_axis_tlast       // last result of this input
);

    localparam int FRAME_LEN = BLOCK_SIZE + 4;
    localparam int POS_W     = $clog2(FRAME_LEN);
    localparam int IDX_W     = (BLOCK_SIZE > 1) ? $clog2(BLOCK_SIZE) : 1;

    localparam logic [POS_W-1:0] POS_NUM      = POS_W'(1);
    localparam logic [POS_W-1:0] POS_INV      = POS_W'(2);
    localparam logic [POS_W-1:0] POS_DATA     = POS_W'(3);
    localparam logic [POS_W-1:0] POS_SUM      = POS_W'(FRAME_LEN - 1);
    localparam logic [IDX_W-1:0] IDX_LAST     = IDX_W'(BLOCK_SIZE - 1);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_UPDATE = 5'b00010,
        ST_CHECK  = 5'b00100,
        ST_WRITE  = 5'b01000,
        ST_REPLY  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // frame state
    logic [POS_W-1:0] r_pos,   n_pos;
    logic [7:0]       r_sum,   n_sum;
    logic [7:0]       r_start, n_start;
    logic [7:0]       r_num,   n_num;
    logic [7:0]       r_inv,   n_inv;
    logic [7:0]       r_blk,   n_blk;
    logic [15:0]      r_base,  n_base;
    logic [15:0]      r_wptr,  n_wptr;
    logic             r_done,  n_done;
    logic [7:0]       r_byte,  n_byte;

    // write-out and reply sequencing
    logic [IDX_W-1:0] r_idx,   n_idx;
    logic [7:0]       r_rep_code, n_rep_code;
    logic             r_rep_last, n_rep_last;
    logic             r_rep_fin,  n_rep_fin;
    logic             r_rep_inc,  n_rep_inc;

    // output register
    logic             r_out_valid, n_out_valid;
    logic             r_out_kind,  n_out_kind;
    logic [7:0]       r_out_pay,   n_out_pay;
    logic [15:0]      r_out_addr,  n_out_addr;
    logic             r_out_last,  n_out_last;
    logic             r_out_fin,   n_out_fin;

    // block buffer
    logic [7:0]       r_mem [BLOCK_SIZE];
    logic [7:0]       r_rd_data;
    logic [IDX_W-1:0] w_rd_addr;
    logic [IDX_W-1:0] w_wr_addr;
    logic             w_wr_en;

    t_alu_req w_alu_req;
    t_alu_rsp w_alu_rsp;

    logic w_in_acc;
    logic w_out_free;
    logic w_load;
    logic w_frame_ok;
    logic w_in_data;

    xcbr_alu u_alu (
        .i_req (w_alu_req),
        .o_rsp (w_alu_rsp)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_addr, r_out_pay};
    assign m_axis_tuser  = {r_out_fin, r_out_kind};
    assign m_axis_tlast  = r_out_last;

    assign w_in_data = (r_pos >= POS_DATA) && (r_pos < POS_SUM);
    assign w_wr_addr = IDX_W'(r_pos - POS_DATA);
    assign w_wr_en   = (r_state == ST_UPDATE) && w_in_data;

    // header checks; the checksum compare comes from the shared adder
    assign w_frame_ok = (r_start == SOH_CODE) && (r_num == r_blk) &&
                        (r_inv == ~r_blk) && w_alu_rsp.zero8;

    // load the output register from the write or reply step
    assign w_load = w_out_free && ((r_state == ST_WRITE) || (r_state == ST_REPLY));

    // next read: advance with each write so data is ready a cycle ahead
    assign w_rd_addr = (r_state == ST_WRITE && w_load && r_idx != IDX_LAST) ?
                       r_idx + IDX_W'(1) : r_idx;

    // shared adder operand select
    always_comb begin
        w_alu_req.op = ALU_ADD;
        w_alu_req.a  = 16'd0;
        w_alu_req.b  = 16'd0;
        case (r_state)
            ST_UPDATE: begin
                w_alu_req.a = {8'd0, r_sum};
                w_alu_req.b = {8'd0, r_byte};
            end
            ST_CHECK: begin
                w_alu_req.op = ALU_SUB;
                w_alu_req.a  = {8'd0, r_byte};
                w_alu_req.b  = {8'd0, r_sum};
            end
            ST_WRITE: begin
                w_alu_req.a = r_wptr;
                w_alu_req.b = 16'd1;
            end
            ST_REPLY: begin
                w_alu_req.a = {8'd0, r_blk};
                w_alu_req.b = 16'd1;
            end
            default: begin
                w_alu_req.op = ALU_ADD;
            end
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_pos      = r_pos;
        n_sum      = r_sum;
        n_start    = r_start;
        n_num      = r_num;
        n_inv      = r_inv;
        n_blk      = r_blk;
        n_base     = r_base;
        n_wptr     = r_wptr;
        n_done     = r_done;
        n_byte     = r_byte;
        n_idx      = r_idx;
        n_rep_code = r_rep_code;
        n_rep_last = r_rep_last;
        n_rep_fin  = r_rep_fin;
        n_rep_inc  = r_rep_inc;

        n_out_valid = r_out_valid;
        n_out_kind  = r_out_kind;
        n_out_pay   = r_out_pay;
        n_out_addr  = r_out_addr;
        n_out_last  = r_out_last;
        n_out_fin   = r_out_fin;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_in_acc && !r_done) begin
                    n_byte = s_axis_tdata;
                    if (s_axis_tuser == KIND_TIMEOUT) begin
                        // short block ends here
                        n_pos      = '0;
                        n_sum      = 8'd0;
                        n_rep_last = 1'b1;
                        n_rep_inc  = 1'b0;
                        if (r_pos == '0) begin
                            n_rep_code = ACK_CODE;
                            n_rep_fin  = 1'b0;
                        end else if (r_start != EOF_CODE) begin
                            n_rep_code = NAK_CODE;
                            n_rep_fin  = 1'b0;
                        end else begin
                            n_rep_code = ACK_CODE;
                            n_rep_fin  = 1'b1;
                        end
                        n_state = ST_REPLY;
                    end else begin
                        n_state = ST_UPDATE;
                    end
                end
            end

            ST_UPDATE: begin
                if (r_pos == '0) begin
                    n_start = r_byte;
                end else if (r_pos == POS_NUM) begin
                    n_num = r_byte;
                end else if (r_pos == POS_INV) begin
                    n_inv = r_byte;
                end else if (w_in_data) begin
                    n_sum = w_alu_rsp.result[7:0];
                end
                if (r_pos == POS_SUM) begin
                    n_state = ST_CHECK;
                end else begin
                    n_pos   = r_pos + POS_W'(1);
                    n_state = ST_IDLE;
                end
            end

            ST_CHECK: begin
                n_pos = '0;
                n_sum = 8'd0;
                n_idx = '0;
                if (w_frame_ok) begin
                    n_state = ST_WRITE;
                end else begin
                    n_rep_code = NAK_CODE;
                    n_rep_inc  = 1'b0;
                    n_rep_fin  = 1'b0;
                    // EOF frame: NAK, then a closing ACK
                    n_rep_last = (r_start != EOF_CODE);
                    n_state    = ST_REPLY;
                end
            end

            ST_WRITE: begin
                if (w_load) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = RES_WRITE;
                    n_out_pay   = r_rd_data;
                    n_out_addr  = r_wptr;
                    n_out_last  = 1'b0;
                    n_out_fin   = 1'b0;
                    n_wptr      = w_alu_rsp.result;
                    if (r_idx == IDX_LAST) begin
                        // park the read at entry 0 for the next block
                        n_idx      = '0;
                        n_rep_code = ACK_CODE;
                        n_rep_last = 1'b1;
                        n_rep_fin  = 1'b0;
                        n_rep_inc  = 1'b1;
                        n_state    = ST_REPLY;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
            end

            ST_REPLY: begin
                if (w_load) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = RES_REPLY;
                    n_out_pay   = r_rep_code;
                    n_out_addr  = 16'd0;
                    n_out_last  = r_rep_last;
                    n_out_fin   = r_rep_fin;
                    if (r_rep_inc) begin
                        n_blk = w_alu_rsp.result[7:0];
                    end
                    if (r_rep_fin) begin
                        n_done = 1'b1;
                    end
                    if (r_rep_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        // second reply of an EOF frame
                        n_rep_code = ACK_CODE;
                        n_rep_last = 1'b1;
                        n_rep_fin  = 1'b1;
                        n_rep_inc  = 1'b0;
                    end
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (i_cfg_wr_en) begin
            n_base = i_cfg_wr_data;
            n_wptr = i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pos       <= '0;
            r_sum       <= 8'd0;
            r_start     <= 8'd0;
            r_num       <= 8'd0;
            r_inv       <= 8'd0;
            r_blk       <= 8'd1;
            r_base      <= 16'd0;
            r_wptr      <= 16'd0;
            r_done      <= 1'b0;
            r_idx       <= '0;
            r_rep_last  <= 1'b1;
            r_rep_fin   <= 1'b0;
            r_rep_inc   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_sum       <= n_sum;
            r_start     <= n_start;
            r_num       <= n_num;
            r_inv       <= n_inv;
            r_blk       <= n_blk;
            r_base      <= n_base;
            r_wptr      <= n_wptr;
            r_done      <= n_done;
            r_idx       <= n_idx;
            r_rep_last  <= n_rep_last;
            r_rep_fin   <= n_rep_fin;
            r_rep_inc   <= n_rep_inc;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_byte     <= n_byte;
        r_rep_code <= n_rep_code;
        r_out_kind <= n_out_kind;
        r_out_pay  <= n_out_pay;
        r_out_addr <= n_out_addr;
        r_out_last <= n_out_last;
        r_out_fin  <= n_out_fin;
    end

    // block buffer, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= r_byte;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

endmodule

/* tb/tb_xmodem_checksum_block_receiver.sv */
`timescale 1ns / 1ps

module tb_xmodem_checksum_block_receiver;
    import xcbr_pkg::*;

    localparam int BLOCK       = 32;
    localparam int FRAME_LEN   = BLOCK + 4;
    localparam int BUF_IDX_W   = $clog2(BLOCK);
    localparam int SETTLE      = 12;     // covers one byte's work plus the check step
    localparam int LONG_HOLD   = 400;    // receiver hold-off, long enough to back up the input
    localparam int IDLE_LIMIT  = 5000;   // cycles with no transaction on either side
    localparam int PHASE_ITEMS = 30;

    typedef struct packed {
        logic        rkind;
        logic [7:0]  payload;
        logic [15:0] addr;
        logic        last;
        logic        fin;
    } t_xfer_result;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic       typed;     // expected reply written out below
        logic [7:0] code;
    } t_dir_row;

    typedef enum {FR_GOOD, FR_BAD_START, FR_BAD_NUM, FR_BAD_INV, FR_BAD_SUM, FR_EOF} t_frame_flavor;
    typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES} t_fill;
    typedef enum {SEQ_GOOD, SEQ_BAD, SEQ_SHORT, SEQ_TIMEOUT, SEQ_NOISE} t_seq;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [15:0] i_cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    // upload tracker: mirrors the receiver's frame state
    logic [7:0]  p_pos;
    logic [7:0]  p_blk;
    logic [7:0]  p_sum;
    logic [7:0]  p_start;
    logic [7:0]  p_num;
    logic [7:0]  p_inv;
    logic [7:0]  p_buf [BLOCK];
    logic [15:0] p_wptr;
    logic        p_done;

    t_xfer_result expected_out [$];
    t_xfer_result want, got;
    t_dir_row     dir_table [12];

    int n_items    = 0;
    int n_errors   = 0;
    int idle_count = 0;
    bit src_quiet  = 1'b0;
    bit sink_quiet = 1'b0;
    bit hold_req   = 1'b0;

    always #5 i_clk = ~i_clk;

    xmodem_checksum_block_receiver #(
        .BLOCK_SIZE (BLOCK)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // mostly back-to-back, some short gaps, a few long ones
    function automatic int pick_gap(bit quiet);
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic t_xfer_result reply(logic [7:0] code, logic last, logic fin);
        return '{RES_REPLY, code, 16'h0000, last, fin};
    endfunction

    // Advance the tracker by one input transaction; queue what it should produce.
    function automatic void upload_predict(logic k, logic [7:0] b, bit keep);
        t_xfer_result res [$];
        bit           good;
        int           i;
        if (p_done) return;
        if (k == KIND_TIMEOUT) begin
            if (p_pos == 0) begin
                res.push_back(reply(ACK_CODE, 1'b1, 1'b0));
            end else if (p_start != EOF_CODE) begin
                res.push_back(reply(NAK_CODE, 1'b1, 1'b0));
            end else begin
                res.push_back(reply(ACK_CODE, 1'b1, 1'b1));
                p_done = 1'b1;
            end
            p_pos = 8'd0;
            p_sum = 8'd0;
        end else begin
            case (p_pos)
                8'd0: p_start = b;
                8'd1: p_num   = b;
                8'd2: p_inv   = b;
                default: begin
                    if (p_pos < 3 + BLOCK) begin
                        p_buf[BUF_IDX_W'(p_pos - 8'd3)] = b;
                        p_sum = p_sum + b;
                    end
                end
            endcase
            if (p_pos < FRAME_LEN - 1) begin
                p_pos = p_pos + 8'd1;
            end else begin
                // closing byte is the checksum
                good = (p_start == SOH_CODE) && (p_num == p_blk) &&
                       (p_inv == ~p_blk) && (b == p_sum);
                if (good) begin
                    for (i = 0; i < BLOCK; i++) begin
                        res.push_back('{RES_WRITE, p_buf[i], p_wptr, 1'b0, 1'b0});
                        p_wptr = p_wptr + 16'd1;
                    end
                    res.push_back(reply(ACK_CODE, 1'b1, 1'b0));
                    p_blk = p_blk + 8'd1;
                end else if (p_start == EOF_CODE) begin
                    res.push_back(reply(NAK_CODE, 1'b0, 1'b0));
                    res.push_back(reply(ACK_CODE, 1'b1, 1'b1));
                    p_done = 1'b1;
                end else begin
                    res.push_back(reply(NAK_CODE, 1'b1, 1'b0));
                end
                p_pos = 8'd0;
                p_sum = 8'd0;
            end
        end
        if (keep) begin
            foreach (res[j]) expected_out.push_back(res[j]);
        end
    endfunction

    // One input transaction. Inputs change on the falling edge; valid stays up
    // across back-to-back transactions.
    task automatic send_item(logic k, logic [7:0] b, bit typed = 1'b0,
                             logic [7:0] code = 8'h00);
        int g;
        g = pick_gap(src_quiet);
        @(negedge i_clk);
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= k;
        s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        n_items++;
        upload_predict(k, b, !typed);
        if (typed) expected_out.push_back(reply(code, 1'b1, 1'b0));
    endtask

    task automatic send_frame(t_frame_flavor flavor, t_fill fill);
        logic [7:0] data [BLOCK];
        logic [7:0] sum, st, num, inv;
        int         i;
        sum = 8'h00;
        for (i = 0; i < BLOCK; i++) begin
            case (fill)
                FILL_ZERO: data[i] = 8'h00;
                FILL_ONES: data[i] = 8'hff;
                default:   data[i] = 8'($urandom);
            endcase
            sum = sum + data[i];
        end
        st  = SOH_CODE;
        num = p_blk;
        inv = ~p_blk;
        case (flavor)
            FR_BAD_START: begin
                do st = 8'($urandom); while (st == SOH_CODE || st == EOF_CODE);
            end
            FR_BAD_NUM: begin
                num = p_blk + 8'($urandom_range(1, 255));
                if ($urandom_range(0, 1) == 1) inv = ~num;
            end
            FR_BAD_INV: inv = inv ^ 8'($urandom_range(1, 255));
            FR_BAD_SUM: sum = sum + 8'($urandom_range(1, 255));
            FR_EOF:     st  = EOF_CODE;
            default: ;
        endcase
        send_item(KIND_BYTE, st);
        send_item(KIND_BYTE, num);
        send_item(KIND_BYTE, inv);
        for (i = 0; i < BLOCK; i++) send_item(KIND_BYTE, data[i]);
        send_item(KIND_BYTE, sum);
    endtask

    // partial frame cut short by a timeout; never led by EOF here
    task automatic send_short();
        int         n, i;
        logic [7:0] b;
        n = $urandom_range(1, FRAME_LEN - 1);
        for (i = 0; i < n; i++) begin
            b = 8'($urandom);
            if (i == 0) begin
                if ($urandom_range(0, 1) == 1 || b == EOF_CODE) b = SOH_CODE;
            end
            send_item(KIND_BYTE, b);
        end
        send_item(KIND_TIMEOUT, 8'($urandom));
    endtask

    // random bytes with stray timeouts, closed by a timeout to resync
    task automatic send_noise();
        int         n, i;
        logic [7:0] b;
        n = $urandom_range(1, 50);
        for (i = 0; i < n; i++) begin
            b = 8'($urandom);
            if (p_pos == 0 && b == EOF_CODE) b = SOH_CODE;
            if ($urandom_range(0, 9) == 0) send_item(KIND_TIMEOUT, b);
            else                           send_item(KIND_BYTE, b);
        end
        send_item(KIND_TIMEOUT, 8'($urandom));
    endtask

    task automatic run_sequence(t_seq which);
        t_fill fill;
        src_quiet = ($urandom_range(0, 4) == 0);
        case ($urandom_range(0, 9))
            0:       fill = FILL_ZERO;
            1:       fill = FILL_ONES;
            default: fill = FILL_RANDOM;
        endcase
        case (which)
            SEQ_GOOD:    send_frame(FR_GOOD, fill);
            SEQ_BAD:     send_frame(t_frame_flavor'($urandom_range(FR_BAD_START, FR_BAD_SUM)),
                                    fill);
            SEQ_SHORT:   send_short();
            SEQ_TIMEOUT: send_item(KIND_TIMEOUT, 8'($urandom));
            default:     send_noise();
        endcase
    endtask

    function automatic t_seq pick_sequence();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return SEQ_GOOD;
        if (r < 72) return SEQ_BAD;
        if (r < 84) return SEQ_SHORT;
        if (r < 90) return SEQ_TIMEOUT;
        return SEQ_NOISE;
    endfunction

    task automatic run_random(int target);
        int start;
        start = n_items;
        while (n_items - start < target) run_sequence(pick_sequence());
    endtask

    // stop sending and wait for every queued result, plus the tail of any
    // byte that produces nothing
    task automatic drain_outputs();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_out.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_base(logic [15:0] v);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        p_wptr = v;
    endtask

    function automatic void cmp_field(string name, int want_v, int got_v);
        if (want_v != got_v) begin
            n_errors++;
            $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                     $time, name, want_v, got_v);
        end
    endfunction

    // output check: every result transaction against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '{m_axis_tuser[0], m_axis_tdata[7:0], m_axis_tdata[23:8],
                    m_axis_tlast, m_axis_tuser[1]};
            if (expected_out.size() == 0) begin
                n_errors++;
                $display("%0t ns: unexpected result, expected none, actual %h",
                         $time, got);
            end else begin
                want = expected_out.pop_front();
                cmp_field("result_kind", int'(want.rkind), int'(got.rkind));
                cmp_field("payload", int'(want.payload), int'(got.payload));
                cmp_field("write_address", int'(want.addr), int'(got.addr));
                cmp_field("last", int'(want.last), int'(got.last));
                cmp_field("finished", int'(want.fin), int'(got.fin));
            end
        end
    end

    // watchdog: no transaction on either side for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_count = 0;
            else
                idle_count++;
            if (idle_count >= IDLE_LIMIT) begin
                $display("%0t ns: no transaction for %0d cycles", $time, IDLE_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // result side: random back-pressure, quiet stretches, one long hold-off
    initial begin : sink_side
        int g;
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 63) == 0) sink_quiet = !sink_quiet;
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                g = pick_gap(sink_quiet);
                if (g > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (g) @(negedge i_clk);
                end
            end
            m_axis_tready <= 1'b1;
        end
    end

    initial begin : stimulus
        int i;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = 16'h0000;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tuser  = KIND_BYTE;

        p_pos   = 8'd0;
        p_blk   = 8'd1;
        p_sum   = 8'd0;
        p_start = 8'd0;
        p_num   = 8'd0;
        p_inv   = 8'd0;
        p_wptr  = 16'h0000;
        p_done  = 1'b0;
        foreach (p_buf[j]) p_buf[j] = 8'h00;

        // short partial frames and bare timeouts; every reply here is plain
        dir_table = '{
            '{KIND_TIMEOUT, 8'h00, 1'b1, ACK_CODE},   // nothing received yet
            '{KIND_TIMEOUT, 8'hff, 1'b1, ACK_CODE},
            '{KIND_BYTE,    8'hff, 1'b0, 8'h00},
            '{KIND_BYTE,    8'h00, 1'b0, 8'h00},
            '{KIND_TIMEOUT, 8'h00, 1'b1, NAK_CODE},   // partial, not EOF led
            '{KIND_BYTE,    SOH_CODE, 1'b0, 8'h00},
            '{KIND_BYTE,    8'h01, 1'b0, 8'h00},
            '{KIND_BYTE,    8'hfe, 1'b0, 8'h00},
            '{KIND_BYTE,    8'h80, 1'b0, 8'h00},
            '{KIND_BYTE,    8'h7f, 1'b0, 8'h00},
            '{KIND_TIMEOUT, 8'h55, 1'b1, NAK_CODE},   // partial SOH frame dropped
            '{KIND_TIMEOUT, 8'haa, 1'b1, ACK_CODE}
        };

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // phase 0: lowest base, directed items
        write_base(16'h0000);
        for (i = 0; i < $size(dir_table); i++)
            send_item(dir_table[i].kind, dir_table[i].data, dir_table[i].typed,
                      dir_table[i].code);
        drain_outputs();

        // phase 1: base just below the top, first block wraps the address
        write_base(16'hfff0);
        src_quiet = 1'b0;
        send_frame(FR_GOOD, FILL_ZERO);
        send_frame(FR_GOOD, FILL_ONES);
        run_random(PHASE_ITEMS);
        drain_outputs();

        // phase 2: top base; receiver holds off while good blocks keep coming
        write_base(16'hffff);
        hold_req = 1'b1;
        src_quiet = 1'b1;
        send_frame(FR_GOOD, FILL_RANDOM);
        send_frame(FR_GOOD, FILL_RANDOM);
        run_random(PHASE_ITEMS);
        drain_outputs();

        // phases 3 and 4: random bases
        write_base(16'($urandom_range(0, 65535)));
        run_random(PHASE_ITEMS);
        drain_outputs();

        write_base(16'($urandom_range(0, 65535)));
        run_random(PHASE_ITEMS);

        // end of transfer: EOF-led partial block or a full EOF-led frame
        src_quiet = 1'b0;
        if ($urandom_range(0, 1) == 0) begin
            send_item(KIND_BYTE, EOF_CODE);
            repeat ($urandom_range(0, 20)) send_item(KIND_BYTE, 8'($urandom));
            send_item(KIND_TIMEOUT, 8'($urandom));
        end else begin
            send_frame(FR_EOF, FILL_RANDOM);
        end
        // transfer is over: these are taken and dropped
        repeat (8) send_item(logic'($urandom_range(0, 1)), 8'($urandom));

        drain_outputs();
        repeat (40) @(posedge i_clk);
        if (n_errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
